/* rtl/stack_machine_muldiv_unit_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the stack machine multiply/divide unit
// Concurrent checks are compiled in unless SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_MULDIV_UNIT_TOP_MACROS_SVH
`define STACK_MACHINE_MULDIV_UNIT_TOP_MACROS_SVH

`ifndef SYNTH

// Check that prop holds at every clock edge outside reset.
`define SMMD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("smmd assertion failed");

// Check that a condition never occurs outside reset.
`define SMMD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("smmd forbidden condition seen");

`else

`define SMMD_ASSERT(lbl, clk, rstn, prop)
`define SMMD_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

/* rtl/smmd_pkg.sv */
// ----------------------------------------------------------------------------
// smmd_pkg
// Shared types, constants and helpers of the multiply/divide unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smmd_pkg;

  localparam int unsigned SMMD_WORD_W    = 32;
  localparam int unsigned SMMD_DWORD_W   = 2 * SMMD_WORD_W;
  // One restoring-division cell per quotient bit of the 64-bit dividend.
  localparam int unsigned SMMD_NUM_CELLS = SMMD_DWORD_W;
  // Accept edge to the edge that takes the result.
  localparam int unsigned SMMD_LATENCY   = SMMD_NUM_CELLS + 3;

  localparam logic SMMD_STATUS_OK       = 1'b0;
  localparam logic SMMD_STATUS_DIV_ZERO = 1'b1;

  typedef enum logic [1:0] {
    CMD_MULU  = 2'd0,
    CMD_MULS  = 2'd1,
    CMD_DIVU  = 2'd2,
    CMD_SCALE = 2'd3
  } smmd_cmd_e;

  typedef struct packed {
    smmd_cmd_e               cmd;
    logic [SMMD_WORD_W-1:0]  operand_a;
    logic [SMMD_WORD_W-1:0]  operand_b;
    logic [SMMD_WORD_W-1:0]  operand_c;
  } smmd_req_t;

  typedef struct packed {
    logic [SMMD_WORD_W-1:0]  first_word;
    logic [SMMD_WORD_W-1:0]  second_word;
    logic [SMMD_WORD_W-1:0]  third_word;
    logic                    status;
  } smmd_rsp_t;

  // Data handed from one division cell to the next.
  typedef struct packed {
    logic                    vld;
    logic                    en;    // divide active: shift/subtract in each cell
    smmd_cmd_e               cmd;
    logic                    pneg;  // product / dividend negative
    logic                    qneg;  // quotient negative
    logic                    dz;    // divisor is zero
    logic [SMMD_WORD_W-1:0]  dvs;   // divisor magnitude
    logic [SMMD_WORD_W-1:0]  rem;   // partial remainder
    logic [SMMD_DWORD_W-1:0] dq;    // dividend bits out, quotient bits in
  } smmd_stage_t;

  function automatic logic [SMMD_WORD_W-1:0] smmd_mag(input logic [SMMD_WORD_W-1:0] v);
    return v[SMMD_WORD_W-1] ? (SMMD_WORD_W'(0) - v) : v;
  endfunction

endpackage

/* rtl/smmd_mul_stage.sv */
// ----------------------------------------------------------------------------
// smmd_mul_stage
// Operand conditioning and the 32x32 multiplier that feeds the cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smmd_mul_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  smmd_pkg::smmd_req_t req_i,
  output smmd_pkg::smmd_stage_t stage_o
);
  import smmd_pkg::*;

  logic                   s1_vld_q;
  smmd_cmd_e              s1_cmd_q,  s1_cmd_d;
  logic [SMMD_WORD_W-1:0] s1_op1_q,  s1_op1_d;
  logic [SMMD_WORD_W-1:0] s1_op2_q,  s1_op2_d;
  logic [SMMD_WORD_W-1:0] s1_dvs_q,  s1_dvs_d;
  logic                   s1_pneg_q, s1_pneg_d;
  logic                   s1_qneg_q, s1_qneg_d;
  logic                   s1_dz_q,   s1_dz_d;

  logic                   is_signed;
  logic                   is_div;
  logic [SMMD_DWORD_W-1:0] product;
  smmd_stage_t            stage_d, stage_q;

  // Stage 1: take magnitudes and signs.
  always_comb begin
    is_signed = req_i.cmd inside {CMD_MULS, CMD_SCALE};
    is_div    = req_i.cmd inside {CMD_DIVU, CMD_SCALE};
    s1_cmd_d  = req_i.cmd;
    s1_op1_d  = is_signed ? smmd_mag(req_i.operand_a) : req_i.operand_a;
    s1_op2_d  = is_signed ? smmd_mag(req_i.operand_b) : req_i.operand_b;
    s1_pneg_d = is_signed &
                (req_i.operand_a[SMMD_WORD_W-1] ^ req_i.operand_b[SMMD_WORD_W-1]);
    s1_dvs_d  = (req_i.cmd == CMD_SCALE) ? smmd_mag(req_i.operand_c) : req_i.operand_c;
    s1_qneg_d = (req_i.cmd == CMD_SCALE) & (s1_pneg_d ^ req_i.operand_c[SMMD_WORD_W-1]);
    s1_dz_d   = is_div & (req_i.operand_c == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q  <= s1_cmd_d;
    s1_op1_q  <= s1_op1_d;
    s1_op2_q  <= s1_op2_d;
    s1_dvs_q  <= s1_dvs_d;
    s1_pneg_q <= s1_pneg_d;
    s1_qneg_q <= s1_qneg_d;
    s1_dz_q   <= s1_dz_d;
  end

  // Stage 2: multiply; an unsigned divide takes its dividend straight.
  always_comb begin
    product       = SMMD_DWORD_W'(s1_op1_q) * SMMD_DWORD_W'(s1_op2_q);
    stage_d.vld   = s1_vld_q;
    stage_d.en    = s1_cmd_q inside {CMD_DIVU, CMD_SCALE};
    stage_d.cmd   = s1_cmd_q;
    stage_d.pneg  = s1_pneg_q;
    stage_d.qneg  = s1_qneg_q;
    stage_d.dz    = s1_dz_q;
    stage_d.dvs   = s1_dvs_q;
    stage_d.rem   = '0;
    stage_d.dq    = (s1_cmd_q == CMD_DIVU) ? {s1_op2_q, s1_op1_q} : product;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

/* rtl/smmd_div_cell.sv */
// ----------------------------------------------------------------------------
// smmd_div_cell
// One restoring-division step: develop one quotient bit, pass on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smmd_div_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smmd_pkg::smmd_stage_t stage_i,
  output smmd_pkg::smmd_stage_t stage_o
);
  import smmd_pkg::*;

  logic [SMMD_WORD_W:0] shifted;
  logic [SMMD_WORD_W:0] diff;
  logic                 qbit;
  smmd_stage_t          stage_d, stage_q;

  always_comb begin
    shifted = {stage_i.rem, stage_i.dq[SMMD_DWORD_W-1]};
    diff    = shifted - {1'b0, stage_i.dvs};
    qbit    = ~diff[SMMD_WORD_W];
    stage_d = stage_i;
    // Multiplies ride through untouched.
    if (stage_i.en) begin
      stage_d.rem = qbit ? diff[SMMD_WORD_W-1:0] : shifted[SMMD_WORD_W-1:0];
      stage_d.dq  = {stage_i.dq[SMMD_DWORD_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

/* rtl/smmd_out_stage.sv */
// ----------------------------------------------------------------------------
// smmd_out_stage
// Sign fix-up, word selection and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smmd_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smmd_pkg::smmd_stage_t stage_i,
  output logic                  valid_o,
  output smmd_pkg::smmd_rsp_t   rsp_o
);
  import smmd_pkg::*;

  logic [SMMD_DWORD_W-1:0] prod_fix;
  logic [SMMD_WORD_W-1:0]  q_lo;
  logic                    vld_q;
  smmd_rsp_t               rsp_d, rsp_q;

  always_comb begin
    prod_fix = stage_i.pneg ? (SMMD_DWORD_W'(0) - stage_i.dq) : stage_i.dq;
    q_lo     = stage_i.dq[SMMD_WORD_W-1:0];
    rsp_d    = '0;
    case (stage_i.cmd)
      CMD_MULU: begin
        rsp_d.first_word  = stage_i.dq[SMMD_WORD_W-1:0];
        rsp_d.second_word = stage_i.dq[SMMD_DWORD_W-1:SMMD_WORD_W];
      end
      CMD_MULS: begin
        rsp_d.first_word  = prod_fix[SMMD_WORD_W-1:0];
        rsp_d.second_word = prod_fix[SMMD_DWORD_W-1:SMMD_WORD_W];
      end
      CMD_DIVU: begin
        rsp_d.first_word  = stage_i.rem;
        rsp_d.second_word = q_lo;
        rsp_d.third_word  = stage_i.dq[SMMD_DWORD_W-1:SMMD_WORD_W];
      end
      CMD_SCALE: begin
        // Remainder follows the product sign, quotient truncates toward zero.
        rsp_d.first_word  = stage_i.pneg ? (SMMD_WORD_W'(0) - stage_i.rem) : stage_i.rem;
        rsp_d.second_word = stage_i.qneg ? (SMMD_WORD_W'(0) - q_lo) : q_lo;
      end
      default: begin
        rsp_d = '0;
      end
    endcase
    rsp_d.status = SMMD_STATUS_OK;
    // Zero divisor: drop the words, flag the error.
    if (stage_i.dz) begin
      rsp_d        = '0;
      rsp_d.status = SMMD_STATUS_DIV_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= stage_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign valid_o = vld_q;
  assign rsp_o   = rsp_q;

endmodule

/* rtl/stack_machine_muldiv_unit_top.sv */
// ----------------------------------------------------------------------------
// stack_machine_muldiv_unit_top: double-cell multiply/divide for a stack machine
// Pipeline: from the accepting edge, each command passes through the stages
//   (2 operand and multiplier stages, 64 division cells, 1 result register);
//   result_valid_o rises for every accepted item.
// Throughput: one transaction per cycle; busy_o is low except out of reset.
// Reset: asynchronous, active low; clears all valid bits, sets busy_o, which drops in the cycle after release.
// The receiver cannot stall: each result is on the ports for one cycle only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_machine_muldiv_unit_top_macros.svh"

module stack_machine_muldiv_unit_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  smmd_pkg::smmd_req_t req_i,
  output logic                result_valid_o,
  output smmd_pkg::smmd_rsp_t rsp_o
);
  import smmd_pkg::*;

  // Hold off transactions while reset is applied and in the cycle after its release.
  logic busy_q;
  logic accept;

  // Chain of stage records: entry 0 comes from the multiplier, entry k from cell k-1.
  smmd_stage_t chain [SMMD_NUM_CELLS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i & ~busy_q;

  // Condition operands and form the 64-bit product or dividend.
  smmd_mul_stage u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .stage_o  (chain[0])
  );

  // Advance one quotient bit per cell; multiplies pass straight down the row.
  for (genvar gi = 0; gi < SMMD_NUM_CELLS; gi++) begin : g_cell
    smmd_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (chain[gi]),
      .stage_o (chain[gi+1])
    );
  end

  // Apply signs, pick the words and register the result.
  smmd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (chain[SMMD_NUM_CELLS]),
    .valid_o (result_valid_o),
    .rsp_o   (rsp_o)
  );

  // Every transaction yields its result a fixed latency later.
  `SMMD_ASSERT(a_result_from_accept, clk_i, rst_ni, accept |-> ##SMMD_LATENCY result_valid_o)
  // Error status only ever answers a divide command.
  `SMMD_ASSERT(a_status_div_only, clk_i, rst_ni, (result_valid_o && rsp_o.status) |-> ($past(req_i.cmd, SMMD_LATENCY) == CMD_DIVU || $past(req_i.cmd, SMMD_LATENCY) == CMD_SCALE))
  // A zero divisor result never carries data words.
  `SMMD_ASSERT_NEVER(a_div_zero_words, clk_i, rst_ni, result_valid_o && rsp_o.status && (rsp_o.first_word != '0 || rsp_o.second_word != '0 || rsp_o.third_word != '0))

endmodule

/* tb/stack_machine_muldiv_unit_top_tb.sv */
// ----------------------------------------------------------------------------
// Testbench for the stack machine multiply/divide unit
// Drives multiply, divide and signed scale commands into the unit and checks
// every result word and the status against an in-bench calculation, in the
// order the commands were taken. A directed set of edge values comes first,
// then random commands under three levels of idle time on the command side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_machine_muldiv_unit_top_tb;
  import smmd_pkg::*;

  // Expected results of accepted commands, oldest first.
  class muldiv_scoreboard;
    smmd_rsp_t   outstanding[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned per_cmd[4];
    int unsigned div_zero_cnt;

    function logic [SMMD_WORD_W-1:0] abs_word(logic [SMMD_WORD_W-1:0] v);
      return v[SMMD_WORD_W-1] ? -v : v;
    endfunction

    // Compute the three result words and status of one command.
    function smmd_rsp_t predict_muldiv(smmd_req_t r);
      smmd_rsp_t                res;
      logic [SMMD_WORD_W-1:0]  a, b, c;
      logic [SMMD_DWORD_W-1:0] prod, quo, rem, dividend;
      logic                    pneg, dneg;
      res = '0;
      res.status = SMMD_STATUS_OK;
      a = r.operand_a;
      b = r.operand_b;
      c = r.operand_c;
      case (r.cmd)
        CMD_MULU: begin
          prod = {32'b0, a} * {32'b0, b};
          res.first_word  = prod[31:0];
          res.second_word = prod[63:32];
        end
        CMD_MULS: begin
          prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
          res.first_word  = prod[31:0];
          res.second_word = prod[63:32];
        end
        default: begin
          if (c == '0) begin
            res.status = SMMD_STATUS_DIV_ZERO;
          end else if (r.cmd == CMD_DIVU) begin
            dividend = {b, a};
            quo = dividend / {32'b0, c};
            rem = dividend % {32'b0, c};
            res.first_word  = rem[31:0];
            res.second_word = quo[31:0];
            res.third_word  = quo[63:32];
          end else begin
            prod = {32'b0, abs_word(a)} * {32'b0, abs_word(b)};
            quo  = prod / {32'b0, abs_word(c)};
            rem  = prod % {32'b0, abs_word(c)};
            pneg = (a[31] ^ b[31]) && (prod != '0);
            dneg = c[31];
            if (pneg) rem = -rem;
            if (pneg != dneg) quo = -quo;
            res.first_word  = rem[31:0];
            res.second_word = quo[31:0];
          end
        end
      endcase
      return res;
    endfunction

    function void note_request(smmd_req_t r);
      outstanding.push_back(predict_muldiv(r));
      per_cmd[int'(r.cmd)]++;
      if (r.cmd inside {CMD_DIVU, CMD_SCALE} && r.operand_c == '0) div_zero_cnt++;
    endfunction

    function void compare_word(string field, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(smmd_rsp_t got);
      smmd_rsp_t exp_r;
      if (outstanding.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got %h", $time, got);
        errors++;
        return;
      end
      exp_r = outstanding.pop_front();
      checked++;
      compare_word("first_word",  exp_r.first_word,  got.first_word);
      compare_word("second_word", exp_r.second_word, got.second_word);
      compare_word("third_word",  exp_r.third_word,  got.third_word);
      compare_word("status",      32'(exp_r.status), 32'(got.status));
    endfunction
  endclass

  localparam int unsigned RANDOM_PER_PHASE = 200;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  smmd_req_t req_i;
  logic      result_valid_o;
  smmd_rsp_t rsp_o;

  muldiv_scoreboard sb;

  stack_machine_muldiv_unit_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sample at the rising edge: values read here are the ones the edge takes,
  // since every driver updates with nonblocking assignments. Check the result
  // before noting the command so a same-edge pair never confuses the order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(rsp_o);
      if (start_i && !busy_o) sb.note_request(req_i);
    end
  end

  // Build one command.
  function automatic smmd_req_t make_req(smmd_cmd_e cmd, logic [31:0] a, logic [31:0] b,
                                         logic [31:0] c);
    smmd_req_t r;
    r.cmd       = cmd;
    r.operand_a = a;
    r.operand_b = b;
    r.operand_c = c;
    return r;
  endfunction

  // Pick an operand: mostly full-range random, with a bias toward the sign
  // boundary, all-ones and small magnitudes of either sign.
  function automatic logic [31:0] pick_word();
    logic [31:0] corners[5];
    corners = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    case ($urandom_range(9))
      0, 1:    return corners[$urandom_range(4)];
      2:       return 32'($urandom_range(255));
      3:       return -32'($urandom_range(1, 255));
      4:       return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  // Hold the command on the port until the unit takes it, then idle the
  // command side for a random gap: each cycle idles with idle_pct percent.
  // Leave start_i high when no gap follows so back-to-back commands stream.
  task automatic send_command(input smmd_req_t r, input int unsigned idle_pct);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      req_i   <= make_req(smmd_cmd_e'($urandom_range(3)), $urandom, $urandom, $urandom);
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic send_random(input int unsigned idle_pct);
    smmd_req_t r;
    r.cmd       = smmd_cmd_e'($urandom_range(3));
    r.operand_a = pick_word();
    r.operand_b = pick_word();
    // Hit the zero divisor now and then; it is ignored by the multiplies.
    r.operand_c = ($urandom_range(99) < 6) ? 32'h0 : pick_word();
    // Keep some unsigned divides with a 32-bit quotient, high word below divisor.
    if (r.cmd == CMD_DIVU && r.operand_c != '0 && $urandom_range(3) == 0)
      r.operand_b = 32'($urandom_range(0, 0)) | (r.operand_b % r.operand_c);
    send_command(r, idle_pct);
  endtask

  initial begin
    int unsigned idle_pct[3];
    idle_pct = '{27, 79, 0};
    sb      = new();
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: edge values of every command.
    send_command(make_req(CMD_MULU,  32'h0000_0000, 32'hFFFF_FFFF, 32'h0), 27);
    send_command(make_req(CMD_MULU,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 27);
    send_command(make_req(CMD_MULU,  32'h8000_0000, 32'h0000_0002, 32'h1234_5678), 27);
    send_command(make_req(CMD_MULS,  32'h8000_0000, 32'h8000_0000, 32'h0), 27);
    send_command(make_req(CMD_MULS,  32'h8000_0000, 32'hFFFF_FFFF, 32'h0), 27);
    send_command(make_req(CMD_MULS,  32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF), 27);
    send_command(make_req(CMD_MULS,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0), 27);
    send_command(make_req(CMD_MULS,  32'h0000_0000, 32'h8000_0000, 32'h0), 27);
    // Unsigned divide: zero divisor, full quotient, divisor at both ends.
    send_command(make_req(CMD_DIVU,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0), 27);
    send_command(make_req(CMD_DIVU,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1), 27);
    send_command(make_req(CMD_DIVU,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 27);
    send_command(make_req(CMD_DIVU,  32'h0000_0000, 32'h0000_0000, 32'h8000_0000), 27);
    send_command(make_req(CMD_DIVU,  32'h0000_0007, 32'h0000_0002, 32'h0000_0003), 27);
    send_command(make_req(CMD_DIVU,  32'h8000_0000, 32'h7FFF_FFFE, 32'h7FFF_FFFF), 27);
    // Signed scale: zero divisor, zero product with a negative divisor,
    // remainder following the product sign, wrapped quotient, extreme divisors.
    send_command(make_req(CMD_SCALE, 32'h0000_0005, 32'h0000_0007, 32'h0), 27);
    send_command(make_req(CMD_SCALE, 32'h0000_0000, 32'hFFFF_FFFB, 32'hFFFF_FFFD), 27);
    send_command(make_req(CMD_SCALE, 32'hFFFF_FFF9, 32'h0000_0003, 32'h0000_0004), 27);
    send_command(make_req(CMD_SCALE, 32'h0000_0007, 32'h0000_0003, 32'hFFFF_FFFC), 27);
    send_command(make_req(CMD_SCALE, 32'hFFFF_FFF9, 32'hFFFF_FFFD, 32'hFFFF_FFFC), 27);
    send_command(make_req(CMD_SCALE, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001), 27);
    send_command(make_req(CMD_SCALE, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF), 27);
    send_command(make_req(CMD_SCALE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000), 27);
    send_command(make_req(CMD_SCALE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF), 27);

    // Random: moderate idling, heavy idling, then back-to-back.
    foreach (idle_pct[p]) begin
      repeat (RANDOM_PER_PHASE) send_random(idle_pct[p]);
    end
    start_i <= 1'b0;

    // Drain: wait for every expected result, then watch for strays.
    while (sb.outstanding.size() != 0) @(posedge clk_i);
    repeat (SMMD_LATENCY + 8) @(posedge clk_i);

    $display("Checked %0d results: %0d mulu, %0d muls, %0d divu, %0d scale, %0d zero divisor.",
             sb.checked, sb.per_cmd[0], sb.per_cmd[1], sb.per_cmd[2], sb.per_cmd[3],
             sb.div_zero_cnt);
    $display("Command side ran at 27%%, 79%% and 0%% idle; %0d mismatches.", sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Stop a hung run: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", sb.outstanding.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/smmd_pkg.sv
rtl/smmd_mul_stage.sv
rtl/smmd_div_cell.sv
rtl/smmd_out_stage.sv
rtl/stack_machine_muldiv_unit_top.sv
tb/stack_machine_muldiv_unit_top_tb.sv
